// File: rtl/sprite_frame_sequencer_unit_defines.svh
// Assertion macros for the sprite frame sequencer.
// Used by sprite_frame_sequencer_unit.sv; expects clk and arst_n in scope.
`ifndef SPRITE_FRAME_SEQUENCER_UNIT_DEFINES_SVH
`define SPRITE_FRAME_SEQUENCER_UNIT_DEFINES_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define SFS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define SFS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/sfs_pkg.sv
// Package for the sprite frame sequencer: transaction payload types,
// action and register index codes, fixed field widths. No dependencies.
`timescale 1ns / 1ps

package sfs_pkg;

	// Largest strip the sequencer plays, and the resulting frame count cap
	localparam int MAX_FRAMES = 256;
	localparam logic [8:0] FRAME_CAP = 9'((MAX_FRAMES < 256) ? MAX_FRAMES : 256);

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	// Action codes of an input transaction
	localparam logic [2:0] ACT_TICK    = 3'd0;
	localparam logic [2:0] ACT_TIMED   = 3'd1;
	localparam logic [2:0] ACT_COUNTED = 3'd2;
	localparam logic [2:0] ACT_STOP    = 3'd3;
	localparam logic [2:0] ACT_SELECT  = 3'd4;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_TOTAL   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP_INTERVAL = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_REVERSE_DIR   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_STOP_FRAME    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_HIDE_ON_STOP  = 3'd4;

	// Register reset values (step interval is 0.7 s in 1/1024 s units)
	localparam logic [8:0]  FRAME_TOTAL_RST   = 9'd1;
	localparam logic [23:0] STEP_INTERVAL_RST = 24'd717;

	typedef struct packed {
		logic [2:0]  action;
		logic [15:0] elapsed;
		logic [31:0] duration;
		logic [15:0] repeat_total;
		logic [7:0]  index_in;
	} in_item_t;

	typedef struct packed {
		logic [7:0] frame_index;
		logic       frame_changed;
		logic       visible;
		logic [1:0] play_mode;
	} out_item_t;

endpackage

// File: rtl/sprite_frame_sequencer_unit.sv
// Sprite frame sequencer: animation frame stepping for one sprite strip.
// Depends on sfs_pkg and sprite_frame_sequencer_unit_defines.svh.
//
// Usage:
//   in_valid/in_ready/in_data carry one command or tick per transaction.
//   out_valid/out_ready/out_data return exactly one result per input, in order:
//   drawn frame, frame changed flag, visibility and play mode.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write the five setup registers;
//   cfg_ready is always high. Write them only while no transaction is in flight.
// Timing:
//   An accepted item sits in the input register, is evaluated by
//   the compare-and-add step logic and lands in the result register once
//   that register is free to take it. One item per cycle is sustained while
//   out_ready is high; the single evaluation stage between the registers sets it.
// Stall:
//   While out_ready is low the result register holds and one more item is
//   buffered in the input register; in_ready then drops until the result goes.
// Reset:
//   arst_n clears both registers' valid flags, returns all play state to idle
//   with frame 0 shown, and loads the register reset values.
`timescale 1ns / 1ps
`include "sprite_frame_sequencer_unit_defines.svh"

module sprite_frame_sequencer_unit #(
	parameter int TIME_WIDTH = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  sfs_pkg::in_item_t                  in_data,
	output logic                               out_valid,
	input  logic                               out_ready,
	output sfs_pkg::out_item_t                 out_data,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [sfs_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [sfs_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int CMP_W = (TIME_WIDTH > 32) ? TIME_WIDTH : 32;
	localparam logic [TIME_WIDTH-1:0] TIME_MAX = '1;

	typedef enum logic [1:0] {
		MODE_IDLE    = 2'd0,
		MODE_TIMED   = 2'd1,
		MODE_COUNTED = 2'd2
	} mode_t;

	// Configuration registers
	logic [8:0]  frame_total_q;
	logic [23:0] step_interval_q;
	logic        reverse_dir_q;
	logic [7:0]  stop_frame_q;
	logic        hide_on_stop_q;

	// Input stage
	logic              valid_s1;
	sfs_pkg::in_item_t item_s1;
	logic              fire_s1;

	// Play state
	mode_t                 mode_q, mode_n;
	logic [7:0]            cur_q, cur_n;
	logic [7:0]            drawn_q, drawn_n;
	logic                  stop_done_q, stop_done_n;
	logic                  shown_q, shown_n;
	logic [TIME_WIDTH-1:0] since_q, since_n;
	logic [TIME_WIDTH-1:0] pe_q, pe_n;
	logic [31:0]           limit_q, limit_n;
	logic [15:0]           wanted_q, wanted_n;
	logic [15:0]           done_q, done_n;

	// Result register
	logic               out_valid_q;
	sfs_pkg::out_item_t out_q;
	sfs_pkg::out_item_t out_n;

	// Step datapath
	logic [8:0]            ft_nz;
	logic [8:0]            n_frames;
	logic [7:0]            last_frame;
	logic [7:0]            step_frame;
	logic                  wrapped;
	logic [TIME_WIDTH:0]   since_sum;
	logic [TIME_WIDTH:0]   pe_sum;
	logic [TIME_WIDTH-1:0] since_sat;
	logic [TIME_WIDTH-1:0] pe_sat;
	logic                  step_due;
	logic                  limit_hit;
	logic [15:0]           done_inc;
	logic [7:0]            stop_target;
	logic                  idx_ok;
	logic [7:0]            start_frame;
	logic                  draw_en;
	logic [7:0]            draw_val;
	logic                  changed;

	// Handshakes
	assign cfg_ready = 1'b1;
	assign fire_s1   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Effective frame count and last frame
	assign ft_nz      = (frame_total_q == 9'd0) ? 9'd1 : frame_total_q;
	assign n_frames   = (ft_nz > sfs_pkg::FRAME_CAP) ? sfs_pkg::FRAME_CAP : ft_nz;
	assign last_frame = 8'(n_frames - 9'd1);

	// Next frame in play direction, with wrap at either end
	always_comb begin
		if (reverse_dir_q) begin
			step_frame = (cur_q != 8'd0) ? (cur_q - 8'd1) : last_frame;
		end else begin
			step_frame = (cur_q < last_frame) ? (cur_q + 8'd1) : 8'd0;
		end
	end
	assign wrapped = reverse_dir_q ? (cur_q <= step_frame) : (cur_q >= step_frame);

	// Saturating time accumulators
	assign since_sum = {1'b0, since_q} + (TIME_WIDTH + 1)'(item_s1.elapsed);
	assign pe_sum    = {1'b0, pe_q} + (TIME_WIDTH + 1)'(item_s1.elapsed);
	assign since_sat = since_sum[TIME_WIDTH] ? TIME_MAX : since_sum[TIME_WIDTH-1:0];
	assign pe_sat    = pe_sum[TIME_WIDTH] ? TIME_MAX : pe_sum[TIME_WIDTH-1:0];
	assign step_due  = CMP_W'(since_sat) >= CMP_W'(step_interval_q);
	assign limit_hit = (limit_q != 32'd0) && (CMP_W'(pe_sat) >= CMP_W'(limit_q));

	// Pass counter, saturating
	assign done_inc = (wrapped && (done_q != 16'hFFFF)) ? (done_q + 16'd1) : done_q;

	// Clamped targets
	assign stop_target = ({1'b0, stop_frame_q} < n_frames) ? stop_frame_q : last_frame;
	assign idx_ok      = {1'b0, item_s1.index_in} < n_frames;
	assign start_frame = idx_ok ? item_s1.index_in : last_frame;

	// Evaluate one transaction against the play state
	always_comb begin
		mode_n      = mode_q;
		cur_n       = cur_q;
		stop_done_n = stop_done_q;
		shown_n     = shown_q;
		since_n     = since_q;
		pe_n        = pe_q;
		limit_n     = limit_q;
		wanted_n    = wanted_q;
		done_n      = done_q;
		draw_en     = 1'b0;
		draw_val    = cur_q;

		case (item_s1.action)
			sfs_pkg::ACT_TICK: begin
				unique case (mode_q)
					MODE_TIMED: begin
						since_n = since_sat;
						pe_n    = pe_sat;
						if (limit_hit) begin
							mode_n = MODE_IDLE;
						end else if (step_due) begin
							cur_n    = step_frame;
							draw_en  = 1'b1;
							draw_val = step_frame;
							since_n  = '0;
						end
					end
					MODE_COUNTED: begin
						since_n = since_sat;
						if (step_due) begin
							cur_n   = step_frame;
							since_n = '0;
							done_n  = done_inc;
							if (done_inc >= wanted_q) begin
								mode_n = MODE_IDLE;
							end else begin
								draw_en  = 1'b1;
								draw_val = step_frame;
							end
						end
					end
					default: begin
						// Land on the stop frame once after a play ends
						if (!stop_done_q) begin
							stop_done_n = 1'b1;
							cur_n       = stop_target;
							draw_en     = 1'b1;
							draw_val    = stop_target;
							if (hide_on_stop_q) begin
								shown_n = 1'b0;
							end
						end
					end
				endcase
			end
			sfs_pkg::ACT_TIMED: begin
				wanted_n    = '0;
				done_n      = '0;
				since_n     = '0;
				pe_n        = '0;
				stop_done_n = 1'b0;
				shown_n     = 1'b1;
				mode_n      = MODE_TIMED;
				limit_n     = item_s1.duration;
			end
			sfs_pkg::ACT_COUNTED: begin
				// Drop a counted play with no passes
				if (item_s1.repeat_total != 16'd0) begin
					done_n      = '0;
					since_n     = '0;
					pe_n        = '0;
					limit_n     = '0;
					stop_done_n = 1'b0;
					shown_n     = 1'b1;
					mode_n      = MODE_COUNTED;
					wanted_n    = item_s1.repeat_total;
					cur_n       = start_frame;
					draw_en     = 1'b1;
					draw_val    = start_frame;
				end
			end
			sfs_pkg::ACT_STOP: begin
				mode_n   = MODE_IDLE;
				wanted_n = '0;
				done_n   = '0;
				since_n  = '0;
				pe_n     = '0;
				limit_n  = '0;
			end
			sfs_pkg::ACT_SELECT: begin
				if (idx_ok) begin
					shown_n = 1'b1;
					if ((mode_q == MODE_IDLE) && (cur_q != item_s1.index_in)) begin
						cur_n    = item_s1.index_in;
						draw_en  = 1'b1;
						draw_val = item_s1.index_in;
					end
				end
			end
			default: begin
			end
		endcase

		changed = draw_en && (draw_val != drawn_q);
		drawn_n = draw_en ? draw_val : drawn_q;

		out_n.frame_index   = drawn_n;
		out_n.frame_changed = changed;
		out_n.visible       = shown_n;
		out_n.play_mode     = mode_n;
	end

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_total_q   <= sfs_pkg::FRAME_TOTAL_RST;
			step_interval_q <= sfs_pkg::STEP_INTERVAL_RST;
			reverse_dir_q   <= 1'b0;
			stop_frame_q    <= 8'd0;
			hide_on_stop_q  <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				sfs_pkg::CFG_FRAME_TOTAL:   frame_total_q   <= cfg_data[8:0];
				sfs_pkg::CFG_STEP_INTERVAL: step_interval_q <= cfg_data[23:0];
				sfs_pkg::CFG_REVERSE_DIR:   reverse_dir_q   <= cfg_data[0];
				sfs_pkg::CFG_STOP_FRAME:    stop_frame_q    <= cfg_data[7:0];
				sfs_pkg::CFG_HIDE_ON_STOP:  hide_on_stop_q  <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// Capture input transactions
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_data;
		end
	end

	// Hold play state and the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_IDLE;
			cur_q       <= 8'd0;
			drawn_q     <= 8'd0;
			stop_done_q <= 1'b1;
			shown_q     <= 1'b1;
			since_q     <= '0;
			pe_q        <= '0;
			limit_q     <= '0;
			wanted_q    <= '0;
			done_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire_s1) begin
				mode_q      <= mode_n;
				cur_q       <= cur_n;
				drawn_q     <= drawn_n;
				stop_done_q <= stop_done_n;
				shown_q     <= shown_n;
				since_q     <= since_n;
				pe_q        <= pe_n;
				limit_q     <= limit_n;
				wanted_q    <= wanted_n;
				done_q      <= done_n;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			out_q <= out_n;
		end
	end

	// Checks on play state bookkeeping and stage flow
	`SFS_ASSERT_NOW(a_counted_has_passes, mode_q == MODE_COUNTED, wanted_q != 16'd0, "counted play with no passes wanted")
	`SFS_ASSERT_NOW(a_timed_no_passes, mode_q == MODE_TIMED, (wanted_q == 16'd0) && (done_q == 16'd0), "timed play carries pass counts")
	`SFS_ASSERT_NOW(a_ready_low_cause, !in_ready, valid_s1 && out_valid_q && !out_ready, "input stalled without a full pipe")
	`SFS_ASSERT_NEXT(a_stop_goes_idle, fire_s1 && (item_s1.action == sfs_pkg::ACT_STOP), (mode_q == MODE_IDLE) && (limit_q == 32'd0), "stop did not end play")

endmodule
